// ===== src/vertex_rotate_project_unit_macros.svh =====
// Assertion macros shared by the vertex rotate and project unit.
`ifndef VERTEX_ROTATE_PROJECT_UNIT_MACROS_SVH
`define VERTEX_ROTATE_PROJECT_UNIT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define VRP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Condition in one cycle that implies a condition in the next cycle.
`define VRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/vrp_pkg.sv =====
// Shared types, widths and register indexes of the vertex rotate and project unit.
package vrp_pkg;

    localparam int COORD_W   = 16;
    localparam int FRAC_BITS = 12;
    localparam int TRIG_FRAC = 14;
    localparam int REG_W     = 16;
    localparam int SCR_W     = 12;
    localparam int CFG_IDX_W = 3;
    localparam int COEF_W    = 18;
    localparam int PROD_W    = COEF_W + COORD_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int RAW_W     = SUM_W - TRIG_FRAC;
    localparam int ROT_W     = COORD_W + 1;
    localparam int ZC_W      = COORD_W + 2;
    localparam int ZU_W      = COORD_W + 1;
    localparam int ROT_LIM   = (1 << COORD_W) - 1;
    localparam int MF_W      = ROT_W + REG_W + 1;
    localparam int ZW_W      = ZU_W + SCR_W;
    localparam int MW_W      = MF_W + SCR_W + 1;
    localparam int N_W       = MW_W + 1;
    localparam int DIV_W     = 33;
    localparam int QUO_W     = COORD_W - 1;
    localparam int IN_W      = 3 * COORD_W;
    localparam int OUT_W     = 2 * COORD_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_COS_PITCH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_PITCH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COS_ROLL      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_ROLL      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_SCALE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_OFFSET = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd7;

    // Rotation matrix and projection settings.
    typedef struct packed {
        logic signed [COEF_W-1:0] cp;
        logic signed [COEF_W-1:0] spsr;
        logic signed [COEF_W-1:0] spcr;
        logic signed [COEF_W-1:0] cr;
        logic signed [COEF_W-1:0] sr;
        logic signed [COEF_W-1:0] nsp;
        logic signed [COEF_W-1:0] cpsr;
        logic signed [COEF_W-1:0] cpcr;
        logic [REG_W-1:0]         focal;
        logic [REG_W-1:0]         cam;
        logic [SCR_W-1:0]         width;
        logic [SCR_W-1:0]         height;
    } coef_t;

    // Rotated vertex with shifted depth.
    typedef struct packed {
        logic signed [ROT_W-1:0] rx;
        logic signed [ROT_W-1:0] ry;
        logic signed [ZC_W-1:0]  zc;
        logic                    behind;
        logic                    last;
    } rot_t;

    // Dividend magnitudes and divisor for the divider.
    typedef struct packed {
        logic [DIV_W-1:0] ax;
        logic [DIV_W-1:0] ay;
        logic             neg_x;
        logic             neg_y;
        logic [ZU_W-1:0]  zc;
        logic             behind;
        logic             last;
    } quo_in_t;

endpackage

// ===== src/vrp_coef.sv =====
// Configuration registers and the rotation matrix derived from them.
module vrp_coef
    import vrp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_wdata,
    output coef_t                coef
);

    logic signed [REG_W-1:0] cos_pitch_reg, sin_pitch_reg, cos_roll_reg, sin_roll_reg;
    logic [REG_W-1:0]        focal_reg, cam_reg;
    logic [SCR_W-1:0]        width_reg, height_reg;
    coef_t                   coef_reg, coef_next;

    // Product of two Q2.14 values rounded half up to Q4.14.
    function automatic logic signed [COEF_W-1:0] trig_mul(input logic signed [REG_W-1:0] a,
                                                          input logic signed [REG_W-1:0] b);
        logic signed [2*REG_W-1:0] p;
        logic signed [2*REG_W:0]   s;
        p = a * b;
        s = (2*REG_W+1)'(p) + ((2*REG_W+1)'(1) <<< (TRIG_FRAC - 1));
        return s[TRIG_FRAC+COEF_W-1:TRIG_FRAC];
    endfunction

    // Register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_pitch_reg <= 16'sd16384;
            sin_pitch_reg <= '0;
            cos_roll_reg  <= 16'sd16384;
            sin_roll_reg  <= '0;
            focal_reg     <= 16'd4096;
            cam_reg       <= 16'd12288;
            width_reg     <= 12'd80;
            height_reg    <= 12'd24;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_COS_PITCH:     cos_pitch_reg <= cfg_wdata;
                REG_SIN_PITCH:     sin_pitch_reg <= cfg_wdata;
                REG_COS_ROLL:      cos_roll_reg  <= cfg_wdata;
                REG_SIN_ROLL:      sin_roll_reg  <= cfg_wdata;
                REG_FOCAL_SCALE:   focal_reg     <= cfg_wdata;
                REG_CAMERA_OFFSET: cam_reg       <= cfg_wdata;
                REG_SCREEN_WIDTH:  width_reg     <= cfg_wdata[SCR_W-1:0];
                REG_SCREEN_HEIGHT: height_reg    <= cfg_wdata[SCR_W-1:0];
                default: ;
            endcase
        end
    end

    // Matrix coefficients, refreshed every cycle.
    always_comb begin
        coef_next.cp     = COEF_W'(cos_pitch_reg);
        coef_next.spsr   = trig_mul(sin_pitch_reg, sin_roll_reg);
        coef_next.spcr   = trig_mul(sin_pitch_reg, cos_roll_reg);
        coef_next.cr     = COEF_W'(cos_roll_reg);
        coef_next.sr     = COEF_W'(sin_roll_reg);
        coef_next.nsp    = -COEF_W'(sin_pitch_reg);
        coef_next.cpsr   = trig_mul(cos_pitch_reg, sin_roll_reg);
        coef_next.cpcr   = trig_mul(cos_pitch_reg, cos_roll_reg);
        coef_next.focal  = focal_reg;
        coef_next.cam    = cam_reg;
        coef_next.width  = width_reg;
        coef_next.height = height_reg;
    end

    always_ff @(posedge aclk) begin
        coef_reg <= coef_next;
    end

    assign coef = coef_reg;

endmodule

// ===== src/vrp_rotate.sv =====
// Rotation pipeline: input register, products, sums with rounding, clamp and camera shift.
module vrp_rotate
    import vrp_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [IN_W-1:0] s_tdata,
    input  logic            s_tlast,
    input  coef_t           coef,
    output logic            rot_valid,
    input  logic            rot_ready,
    output rot_t            rot
);

    `include "vertex_rotate_project_unit_macros.svh"

    localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) <<< (TRIG_FRAC - 1);

    logic [3:0]               vld_reg;
    logic [3:0]               rdy;
    logic signed [COORD_W-1:0] vx_reg, vy_reg, vz_reg;
    logic [2:0]               last_reg;
    logic signed [PROD_W-1:0] prod_reg [8];
    logic signed [PROD_W-1:0] prod_next [8];
    logic signed [SUM_W-1:0]  sum_x, sum_y, sum_z;
    logic signed [RAW_W-1:0]  rx_reg, ry_reg, rz_reg;
    logic signed [RAW_W-1:0]  rx_next, ry_next, rz_next;
    rot_t                     rot_reg, rot_next;

    // Saturate a rounded rotation result to the symmetric limit.
    function automatic logic signed [ROT_W-1:0] clamp_rot(input logic signed [RAW_W-1:0] v);
        logic signed [RAW_W-1:0] lim;
        lim = RAW_W'(ROT_LIM);
        if (v > lim) begin
            return ROT_W'(lim);
        end else if (v < -lim) begin
            return ROT_W'(-lim);
        end
        return ROT_W'(v);
    endfunction

    // Each stage advances when empty or when the next one advances.
    assign rdy[3]   = !vld_reg[3] || rot_ready;
    assign rdy[2]   = !vld_reg[2] || rdy[3];
    assign rdy[1]   = !vld_reg[1] || rdy[2];
    assign rdy[0]   = !vld_reg[0] || rdy[1];
    assign s_tready = rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) vld_reg[0] <= s_tvalid;
            if (rdy[1]) vld_reg[1] <= vld_reg[0];
            if (rdy[2]) vld_reg[2] <= vld_reg[1];
            if (rdy[3]) vld_reg[3] <= vld_reg[2];
        end
    end

    // Matrix products.
    always_comb begin
        prod_next[0] = coef.cp   * vx_reg;
        prod_next[1] = coef.spsr * vy_reg;
        prod_next[2] = coef.spcr * vz_reg;
        prod_next[3] = coef.cr   * vy_reg;
        prod_next[4] = coef.sr   * vz_reg;
        prod_next[5] = coef.nsp  * vx_reg;
        prod_next[6] = coef.cpsr * vy_reg;
        prod_next[7] = coef.cpcr * vz_reg;
    end

    // Row sums rounded half up to the coordinate scale.
    always_comb begin
        sum_x = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2]) + RND;
        sum_y = SUM_W'(prod_reg[3]) - SUM_W'(prod_reg[4]) + RND;
        sum_z = SUM_W'(prod_reg[5]) + SUM_W'(prod_reg[6]) + SUM_W'(prod_reg[7]) + RND;
        rx_next = sum_x[SUM_W-1:TRIG_FRAC];
        ry_next = sum_y[SUM_W-1:TRIG_FRAC];
        rz_next = sum_z[SUM_W-1:TRIG_FRAC];
    end

    // Clamp, then shift depth by the camera distance.
    always_comb begin
        rot_next.rx     = clamp_rot(rx_reg);
        rot_next.ry     = clamp_rot(ry_reg);
        rot_next.zc     = ZC_W'(clamp_rot(rz_reg)) + ZC_W'($signed({1'b0, coef.cam}));
        rot_next.behind = (rot_next.zc <= 0);
        rot_next.last   = last_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            vx_reg      <= s_tdata[COORD_W-1:0];
            vy_reg      <= s_tdata[2*COORD_W-1:COORD_W];
            vz_reg      <= s_tdata[3*COORD_W-1:2*COORD_W];
            last_reg[0] <= s_tlast;
        end
        if (rdy[1]) begin
            prod_reg    <= prod_next;
            last_reg[1] <= last_reg[0];
        end
        if (rdy[2]) begin
            rx_reg      <= rx_next;
            ry_reg      <= ry_next;
            rz_reg      <= rz_next;
            last_reg[2] <= last_reg[1];
        end
        if (rdy[3]) begin
            rot_reg <= rot_next;
        end
    end

    assign rot_valid = vld_reg[3];
    assign rot       = rot_reg;

    `VRP_ASSERT(a_rot_clamped, rot_valid |-> rot.rx != -ROT_W'(ROT_LIM + 1), "rotated x below limit")

endmodule

// ===== src/vrp_scale.sv =====
// Projection scaling: focal and screen products and forming the dividend.
module vrp_scale
    import vrp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    rot_valid,
    output logic    rot_ready,
    input  rot_t    rot,
    input  coef_t   coef,
    output logic    qin_valid,
    input  logic    qin_ready,
    output quo_in_t qin
);

    logic [2:0]              vld_reg;
    logic [2:0]              rdy;
    logic signed [MF_W-1:0]  mfx_reg, mfy_reg;
    logic [ZW_W-1:0]         zw_reg, zh_reg, zw2_reg, zh2_reg;
    logic signed [MW_W-1:0]  mx_reg, my_reg;
    logic [ZU_W-1:0]         zc_reg, zc2_reg;
    logic [1:0]              behind_reg, last_reg;
    logic signed [N_W-1:0]   nx, ny;
    logic [N_W-FRAC_BITS-2:0] shx, shy;
    quo_in_t                 qin_reg, qin_next;

    assign rdy[2]    = !vld_reg[2] || qin_ready;
    assign rdy[1]    = !vld_reg[1] || rdy[2];
    assign rdy[0]    = !vld_reg[0] || rdy[1];
    assign rot_ready = rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) vld_reg[0] <= rot_valid;
            if (rdy[1]) vld_reg[1] <= vld_reg[0];
            if (rdy[2]) vld_reg[2] <= vld_reg[1];
        end
    end

    // Dividend 2*r*f*w + zc*w*2^FRAC_BITS, floored by the constant part of the divisor.
    always_comb begin
        nx  = $signed({mx_reg, 1'b0}) + $signed(N_W'(zw2_reg) << FRAC_BITS);
        ny  = $signed({my_reg, 1'b0}) + $signed(N_W'(zh2_reg) << FRAC_BITS);
        shx = nx[N_W-1:FRAC_BITS+1];
        shy = ny[N_W-1:FRAC_BITS+1];
        qin_next.neg_x  = nx[N_W-1];
        qin_next.neg_y  = ny[N_W-1];
        qin_next.ax     = nx[N_W-1] ? DIV_W'(~shx) : DIV_W'(shx);
        qin_next.ay     = ny[N_W-1] ? DIV_W'(~shy) : DIV_W'(shy);
        qin_next.zc     = zc2_reg;
        qin_next.behind = behind_reg[1];
        qin_next.last   = last_reg[1];
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            mfx_reg       <= rot.rx * $signed({1'b0, coef.focal});
            mfy_reg       <= rot.ry * $signed({1'b0, coef.focal});
            zw_reg        <= rot.zc[ZU_W-1:0] * coef.width;
            zh_reg        <= rot.zc[ZU_W-1:0] * coef.height;
            zc_reg        <= rot.zc[ZU_W-1:0];
            behind_reg[0] <= rot.behind;
            last_reg[0]   <= rot.last;
        end
        if (rdy[1]) begin
            mx_reg        <= mfx_reg * $signed({1'b0, coef.width});
            my_reg        <= mfy_reg * $signed({1'b0, coef.height});
            zw2_reg       <= zw_reg;
            zh2_reg       <= zh_reg;
            zc2_reg       <= zc_reg;
            behind_reg[1] <= behind_reg[0];
            last_reg[1]   <= last_reg[0];
        end
        if (rdy[2]) begin
            qin_reg <= qin_next;
        end
    end

    assign qin_valid = vld_reg[2];
    assign qin       = qin_reg;

endmodule

// ===== src/vrp_divide.sv =====
// Pipelined restoring divider, one quotient bit per stage, with saturation and output register.
module vrp_divide
    import vrp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             qin_valid,
    output logic             qin_ready,
    input  quo_in_t          qin,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast,
    output logic             m_tuser
);

    `include "vertex_rotate_project_unit_macros.svh"

    localparam int NST = QUO_W + 1;

    typedef struct packed {
        logic [DIV_W-1:0] rem_x;
        logic [DIV_W-1:0] rem_y;
        logic [QUO_W-1:0] q_x;
        logic [QUO_W-1:0] q_y;
        logic             neg_x;
        logic             neg_y;
        logic             ovf_x;
        logic             ovf_y;
        logic [ZU_W-1:0]  zc;
        logic             behind;
        logic             last;
    } div_t;

    div_t             st_reg  [NST];
    div_t             st_next [NST];
    logic [NST-1:0]   vld_reg;
    logic [NST:0]     rdy;
    logic             out_vld_reg;
    logic [OUT_W-1:0] data_reg, data_next;
    logic             last_reg, user_reg;

    // Final coordinate from quotient, sign, overflow and the behind-camera case.
    function automatic logic [COORD_W-1:0] finish(input logic [QUO_W-1:0] q, input logic neg,
                                                  input logic ovf, input logic behind);
        logic [COORD_W-1:0] v;
        v = {1'b0, q};
        if (behind) begin
            return '0;
        end else if (ovf) begin
            return neg ? {1'b1, {QUO_W{1'b0}}} : {1'b0, {QUO_W{1'b1}}};
        end
        return neg ? ~v : v;
    endfunction

    // Ready chain from the output register back to the first stage.
    always_comb begin
        rdy[NST] = !out_vld_reg || m_tready;
        for (int j = NST - 1; j >= 0; j--) begin
            rdy[j] = !vld_reg[j] || rdy[j+1];
        end
    end
    assign qin_ready = rdy[0];

    // Overflow check on entry, then one quotient bit per stage from the top down.
    always_comb begin
        st_next[0].rem_x  = qin.ax;
        st_next[0].rem_y  = qin.ay;
        st_next[0].q_x    = '0;
        st_next[0].q_y    = '0;
        st_next[0].neg_x  = qin.neg_x;
        st_next[0].neg_y  = qin.neg_y;
        st_next[0].ovf_x  = qin.ax >= (DIV_W'(qin.zc) << QUO_W);
        st_next[0].ovf_y  = qin.ay >= (DIV_W'(qin.zc) << QUO_W);
        st_next[0].zc     = qin.zc;
        st_next[0].behind = qin.behind;
        st_next[0].last   = qin.last;
        for (int j = 1; j < NST; j++) begin
            st_next[j] = st_reg[j-1];
            if (st_reg[j-1].rem_x >= (DIV_W'(st_reg[j-1].zc) << (QUO_W - j))) begin
                st_next[j].rem_x = st_reg[j-1].rem_x
                                 - (DIV_W'(st_reg[j-1].zc) << (QUO_W - j));
                st_next[j].q_x[QUO_W-j] = 1'b1;
            end
            if (st_reg[j-1].rem_y >= (DIV_W'(st_reg[j-1].zc) << (QUO_W - j))) begin
                st_next[j].rem_y = st_reg[j-1].rem_y
                                 - (DIV_W'(st_reg[j-1].zc) << (QUO_W - j));
                st_next[j].q_y[QUO_W-j] = 1'b1;
            end
        end
    end

    always_comb begin
        data_next = {finish(st_reg[NST-1].q_y, st_reg[NST-1].neg_y,
                            st_reg[NST-1].ovf_y, st_reg[NST-1].behind),
                     finish(st_reg[NST-1].q_x, st_reg[NST-1].neg_x,
                            st_reg[NST-1].ovf_x, st_reg[NST-1].behind)};
    end

    // Stage valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            if (rdy[0]) vld_reg[0] <= qin_valid;
            for (int j = 1; j < NST; j++) begin
                if (rdy[j]) vld_reg[j] <= vld_reg[j-1];
            end
            if (rdy[NST]) out_vld_reg <= vld_reg[NST-1];
        end
    end

    // Stage payload and output register.
    always_ff @(posedge aclk) begin
        for (int j = 0; j < NST; j++) begin
            if (rdy[j]) st_reg[j] <= st_next[j];
        end
        if (rdy[NST]) begin
            data_reg <= data_next;
            last_reg <= st_reg[NST-1].last;
            user_reg <= st_reg[NST-1].behind;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

    `VRP_ASSERT(a_behind_zero, m_tvalid && m_tuser |-> m_tdata == '0, "behind camera with nonzero coordinates")
    `VRP_ASSERT(a_rem_bound, vld_reg[NST-1] && !st_reg[NST-1].behind && !st_reg[NST-1].ovf_x |-> st_reg[NST-1].rem_x < DIV_W'(st_reg[NST-1].zc), "remainder not below divisor")
    `VRP_ASSERT_NEXT(a_stall_hold, vld_reg[NST-1] && !rdy[NST], vld_reg[NST-1], "last divider stage dropped during stall")

endmodule

// ===== src/vertex_rotate_project_unit.sv =====
// Top level of the vertex rotate and project unit.
// Each vertex transaction (x, y, z in signed Q4.12) is rotated by pitch and roll, shifted by the
// camera distance, divided by depth and scaled to screen pixels. One vertex is accepted per
// clock while the output is not stalled. The pipeline has four rotation stages and three
// scaling stages, then the 16-stage restoring divider, whose first stage checks for overflow
// and whose other 15 stages each resolve one quotient bit, and last the output register. The
// user must write configuration registers through cfg_we/cfg_index/cfg_wdata only while no
// vertex is in flight; the block itself does not enforce this.
module vertex_rotate_project_unit
    import vrp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_W-1:0]      s_tdata,   // vertex_x, vertex_y, vertex_z
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata,   // screen_x, screen_y
    output logic                 m_tlast,
    output logic                 m_tuser    // behind_camera
);

    coef_t   coef;
    rot_t    rot;
    quo_in_t qin;
    logic    rot_valid, rot_ready, qin_valid, qin_ready;

    vrp_coef u_coef (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .coef      (coef)
    );

    vrp_rotate u_rotate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .coef      (coef),
        .rot_valid (rot_valid),
        .rot_ready (rot_ready),
        .rot       (rot)
    );

    vrp_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rot_valid (rot_valid),
        .rot_ready (rot_ready),
        .rot       (rot),
        .coef      (coef),
        .qin_valid (qin_valid),
        .qin_ready (qin_ready),
        .qin       (qin)
    );

    vrp_divide u_divide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .qin_valid (qin_valid),
        .qin_ready (qin_ready),
        .qin       (qin),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
